// ===== hdl/face_tracking_gaze_controller_defines.svh =====
// ---------------------------------------------------------------------------
// Face tracking gaze controller: shared assertion macros
// Concurrent checks sampled on i_clk, masked while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FACE_TRACKING_GAZE_CONTROLLER_DEFINES_SVH
`define FACE_TRACKING_GAZE_CONTROLLER_DEFINES_SVH

// General property check on the block clock, masked during reset.
`define FTG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Next-cycle implication check on the block clock.
`define FTG_ASSERT_NEXT(label, cond, expect_next, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

// ===== hdl/ftg_pkg.sv =====
// ---------------------------------------------------------------------------
// ftg_pkg
// Types, codes and reset values for the face tracking gaze controller.
// ---------------------------------------------------------------------------
package ftg_pkg;

    localparam int GainW     = 17;
    localparam int PosW      = 16;
    localparam int GraceW    = 16;
    localparam int DeadbandW = 16;
    localparam int SpeedW    = 10;
    localparam int TimeW     = 32;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 17;

    // Gain of exactly 1.0 in Q1.16
    localparam logic [GainW-1:0] GainOne = 17'h10000;

    localparam logic [GainW-1:0]     GainRst     = 17'd45875;
    localparam logic [GraceW-1:0]    GraceRst    = 16'd1000;
    localparam logic [DeadbandW-1:0] DeadbandRst = 16'd655;
    localparam logic [SpeedW-1:0]    SpeedRst    = 10'd500;
    localparam logic                 WakeRst     = 1'b1;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_GAIN     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GRACE    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_DEADBAND = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SPEED    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_WAKE     = 3'd4;

    // Event codes
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_ACQUIRED = 2'd1;
    localparam logic [1:0] EV_LOST     = 2'd2;

    // Reported tracker state codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TRACK = 2'd1;
    localparam logic [1:0] ST_GRACE = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_TRACK = 3'b010,
        MODE_GRACE = 3'b100
    } t_mode;

    function automatic logic [1:0] mode_code(input t_mode mode);
        logic [1:0] code;
        case (mode)
            MODE_TRACK: code = ST_TRACK;
            MODE_GRACE: code = ST_GRACE;
            default:    code = ST_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/ftg_axis.sv =====
// ---------------------------------------------------------------------------
// ftg_axis
// One axis: exponential smoothing step and deadband test against the last
// issued command.
// ---------------------------------------------------------------------------
module ftg_axis (
    input  logic [ftg_pkg::GainW-1:0]     i_gain,
    input  logic [ftg_pkg::DeadbandW-1:0] i_deadband,
    input  logic signed [ftg_pkg::PosW-1:0] i_smooth,
    input  logic signed [ftg_pkg::PosW-1:0] i_raw,
    input  logic signed [ftg_pkg::PosW-1:0] i_last,
    output logic signed [ftg_pkg::PosW-1:0] o_next,
    output logic                          o_near
);

    logic [ftg_pkg::GainW-1:0] gain_c;
    logic signed [16:0]        delta;
    logic signed [34:0]        prod;
    logic signed [34:0]        rounded;
    logic signed [17:0]        sum;
    logic signed [16:0]        diff;
    logic [16:0]               abs_diff;

    // gain above 1.0 acts as 1.0
    assign gain_c  = (i_gain > ftg_pkg::GainOne) ? ftg_pkg::GainOne : i_gain;
    assign delta   = {i_raw[15], i_raw} - {i_smooth[15], i_smooth};
    assign prod    = $signed({1'b0, gain_c}) * delta;
    // round to nearest, ties toward plus infinity
    assign rounded = prod + 35'sd32768;
    assign sum     = {{2{i_smooth[15]}}, i_smooth} + rounded[33:16];
    assign o_next  = sum[15:0];

    assign diff     = {o_next[15], o_next} - {i_last[15], i_last};
    assign abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
    assign o_near   = abs_diff < {1'b0, i_deadband};

endmodule

// ===== hdl/face_tracking_gaze_controller.sv =====
// ---------------------------------------------------------------------------
// face_tracking_gaze_controller
// Idle / tracking / grace state machine with per-axis smoothing and deadband.
// ---------------------------------------------------------------------------
// Usage:
//   Detector samples enter on i_in_valid / o_in_stall, one per transfer.
//   Every sample gives exactly one result on o_out_valid / i_out_stall:
//   gaze command (look_valid, x, y, rate), event code, wake request,
//   indicator and tracker state after the sample.
//   Configuration registers are written over i_cfg_valid / o_cfg_ready
//   (always ready) with i_cfg_index and i_cfg_data; write only while idle.
//   Indexes: 0 gain, 1 grace time, 2 deadband, 3 look speed, 4 wake enable.
//   The sample lands in the input register, and when it advances the state
//   update and result computation go into the output register. Throughput is
//   one sample per cycle while the receiver does not stall; the state loop
//   through the smoothing multiplier sets that figure.
//   When the receiver stalls, the result holds and one more sample can be
//   taken into the input register before o_in_stall rises.
//   Synchronous reset (i_rst_n low) empties both registers, returns the
//   tracker to idle and loads the default configuration.
// ---------------------------------------------------------------------------
`include "face_tracking_gaze_controller_defines.svh"

module face_tracking_gaze_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ftg_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [ftg_pkg::CfgDataW-1:0]    i_cfg_data,
    // detector samples
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_face_seen,
    input  logic signed [ftg_pkg::PosW-1:0] i_face_x,
    input  logic signed [ftg_pkg::PosW-1:0] i_face_y,
    input  logic [ftg_pkg::TimeW-1:0]       i_now_ms,
    input  logic                            i_motion_locked,
    // results
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_look_valid,
    output logic signed [ftg_pkg::PosW-1:0] o_look_x,
    output logic signed [ftg_pkg::PosW-1:0] o_look_y,
    output logic [ftg_pkg::SpeedW-1:0]      o_look_rate,
    output logic [1:0]                      o_event_code,
    output logic                            o_wake_request,
    output logic                            o_indicator_on,
    output logic [1:0]                      o_tracker_state
);

    // configuration
    logic [ftg_pkg::GainW-1:0]     r_cfg_gain;
    logic [ftg_pkg::GraceW-1:0]    r_cfg_grace;
    logic [ftg_pkg::DeadbandW-1:0] r_cfg_deadband;
    logic [ftg_pkg::SpeedW-1:0]    r_cfg_speed;
    logic                          r_cfg_wake;

    // input register
    logic                            r_in_vld;
    logic                            r_in_seen;
    logic signed [ftg_pkg::PosW-1:0] r_in_x;
    logic signed [ftg_pkg::PosW-1:0] r_in_y;
    logic [ftg_pkg::TimeW-1:0]       r_in_now;
    logic                            r_in_locked;

    // tracker state
    ftg_pkg::t_mode                  r_mode, n_mode;
    logic signed [ftg_pkg::PosW-1:0] r_smooth_x, n_smooth_x;
    logic signed [ftg_pkg::PosW-1:0] r_smooth_y, n_smooth_y;
    logic signed [ftg_pkg::PosW-1:0] r_last_x, n_last_x;
    logic signed [ftg_pkg::PosW-1:0] r_last_y, n_last_y;
    logic                            r_last_known, n_last_known;
    logic [ftg_pkg::TimeW-1:0]       r_grace_start, n_grace_start;

    // output register
    logic                            r_out_vld;
    logic                            r_look_valid, n_look_valid;
    logic signed [ftg_pkg::PosW-1:0] r_look_x, n_look_x;
    logic signed [ftg_pkg::PosW-1:0] r_look_y, n_look_y;
    logic [ftg_pkg::SpeedW-1:0]      r_look_rate, n_look_rate;
    logic [1:0]                      r_event, n_event;
    logic                            r_wake, n_wake;

    logic                            advance;
    logic                            fire;
    logic                            in_xfer;
    logic signed [ftg_pkg::PosW-1:0] ema_x, ema_y;
    logic                            near_x, near_y;
    logic [ftg_pkg::TimeW-1:0]       elapsed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_gain     <= ftg_pkg::GainRst;
            r_cfg_grace    <= ftg_pkg::GraceRst;
            r_cfg_deadband <= ftg_pkg::DeadbandRst;
            r_cfg_speed    <= ftg_pkg::SpeedRst;
            r_cfg_wake     <= ftg_pkg::WakeRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ftg_pkg::CFG_GAIN:     r_cfg_gain     <= i_cfg_data;
                ftg_pkg::CFG_GRACE:    r_cfg_grace    <= i_cfg_data[ftg_pkg::GraceW-1:0];
                ftg_pkg::CFG_DEADBAND: r_cfg_deadband <= i_cfg_data[ftg_pkg::DeadbandW-1:0];
                ftg_pkg::CFG_SPEED:    r_cfg_speed    <= i_cfg_data[ftg_pkg::SpeedW-1:0];
                ftg_pkg::CFG_WAKE:     r_cfg_wake     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: the output register frees up when empty or being taken
    assign advance    = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && advance;
    assign o_in_stall = r_in_vld && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_seen   <= i_face_seen;
            r_in_x      <= i_face_x;
            r_in_y      <= i_face_y;
            r_in_now    <= i_now_ms;
            r_in_locked <= i_motion_locked;
        end
    end

    ftg_axis u_axis_x (
        .i_gain     (r_cfg_gain),
        .i_deadband (r_cfg_deadband),
        .i_smooth   (r_smooth_x),
        .i_raw      (r_in_x),
        .i_last     (r_last_x),
        .o_next     (ema_x),
        .o_near     (near_x)
    );

    ftg_axis u_axis_y (
        .i_gain     (r_cfg_gain),
        .i_deadband (r_cfg_deadband),
        .i_smooth   (r_smooth_y),
        .i_raw      (r_in_y),
        .i_last     (r_last_y),
        .o_next     (ema_y),
        .o_near     (near_y)
    );

    assign elapsed = r_in_now - r_grace_start;

    always_comb begin
        n_mode        = r_mode;
        n_smooth_x    = r_smooth_x;
        n_smooth_y    = r_smooth_y;
        n_last_x      = r_last_x;
        n_last_y      = r_last_y;
        n_last_known  = r_last_known;
        n_grace_start = r_grace_start;
        n_look_valid  = 1'b0;
        n_event       = ftg_pkg::EV_NONE;
        n_wake        = 1'b0;

        case (r_mode)
            ftg_pkg::MODE_TRACK, ftg_pkg::MODE_GRACE: begin
                if (r_in_seen) begin
                    n_mode     = ftg_pkg::MODE_TRACK;
                    n_smooth_x = ema_x;
                    n_smooth_y = ema_y;
                    // drop the command when locked or still inside the deadband
                    if (!r_in_locked && !(r_last_known && near_x && near_y)) begin
                        n_look_valid = 1'b1;
                        n_last_x     = ema_x;
                        n_last_y     = ema_y;
                        n_last_known = 1'b1;
                    end
                end else if (r_mode == ftg_pkg::MODE_TRACK) begin
                    n_mode        = ftg_pkg::MODE_GRACE;
                    n_grace_start = r_in_now;
                end else if (elapsed > {{(ftg_pkg::TimeW-ftg_pkg::GraceW){1'b0}}, r_cfg_grace}) begin
                    n_mode       = ftg_pkg::MODE_IDLE;
                    n_last_known = 1'b0;
                    n_event      = ftg_pkg::EV_LOST;
                end
            end
            default: begin
                n_mode = ftg_pkg::MODE_IDLE;
                if (r_in_seen) begin
                    n_mode       = ftg_pkg::MODE_TRACK;
                    n_smooth_x   = r_in_x;
                    n_smooth_y   = r_in_y;
                    n_last_known = 1'b0;
                    n_event      = ftg_pkg::EV_ACQUIRED;
                    n_wake       = r_cfg_wake;
                end
            end
        endcase

        n_look_x    = n_look_valid ? n_smooth_x : '0;
        n_look_y    = n_look_valid ? n_smooth_y : '0;
        n_look_rate = n_look_valid ? r_cfg_speed : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ftg_pkg::MODE_IDLE;
            r_smooth_x    <= '0;
            r_smooth_y    <= '0;
            r_last_x      <= '0;
            r_last_y      <= '0;
            r_last_known  <= 1'b0;
            r_grace_start <= '0;
        end else if (fire) begin
            r_mode        <= n_mode;
            r_smooth_x    <= n_smooth_x;
            r_smooth_y    <= n_smooth_y;
            r_last_x      <= n_last_x;
            r_last_y      <= n_last_y;
            r_last_known  <= n_last_known;
            r_grace_start <= n_grace_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_look_valid <= n_look_valid;
            r_look_x     <= n_look_x;
            r_look_y     <= n_look_y;
            r_look_rate  <= n_look_rate;
            r_event      <= n_event;
            r_wake       <= n_wake;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_look_valid    = r_look_valid;
    assign o_look_x        = r_look_x;
    assign o_look_y        = r_look_y;
    assign o_look_rate     = r_look_rate;
    assign o_event_code    = r_event;
    assign o_wake_request  = r_wake;
    // state after the last delivered sample: the tracker register itself
    assign o_tracker_state = ftg_pkg::mode_code(r_mode);
    assign o_indicator_on  = (r_mode != ftg_pkg::MODE_IDLE);

    `FTG_ASSERT(a_cmd_not_on_acquire,
        !(r_out_vld && r_look_valid && (r_event == ftg_pkg::EV_ACQUIRED)),
        "gaze command issued on acquisition")
    `FTG_ASSERT(a_wake_only_on_acquire,
        !(r_out_vld && r_wake && (r_event != ftg_pkg::EV_ACQUIRED)),
        "wake request without acquisition")
    `FTG_ASSERT_NEXT(a_lost_goes_idle,
        fire && (n_event == ftg_pkg::EV_LOST),
        r_mode == ftg_pkg::MODE_IDLE && !r_last_known,
        "face lost did not return to idle")
    `FTG_ASSERT_NEXT(a_cmd_records_last,
        fire && n_look_valid,
        r_last_known && (r_last_x == r_smooth_x) && (r_last_y == r_smooth_y),
        "issued command not recorded as last")
    `FTG_ASSERT(a_stall_needs_full,
        !o_in_stall || (r_in_vld && r_out_vld),
        "input stalled while a register is free")

endmodule
